// ===== rtl/core/sorted_price_level_book_top_defines.svh =====
// Assertion macros shared by the price level book RTL.
`ifndef SORTED_PRICE_LEVEL_BOOK_TOP_DEFINES_SVH
`define SORTED_PRICE_LEVEL_BOOK_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SPLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define SPLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/splb_pkg.sv =====
// Shared types and constants of the price level book.
package splb_pkg;

  localparam int LEVELS_DEF = 32;
  localparam int PRICE_W    = 40;
  localparam int SIZE_W     = 48;
  localparam int COUNT_W    = 16;
  localparam int TOL_W      = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 4;

  localparam logic [SIZE_W-1:0] ONE_FX     = SIZE_W'(48'h000001000000);
  localparam logic [SIZE_W-1:0] NEG_ONE_FX = SIZE_W'(48'hFFFFFF000000);

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED   = 4'd0,
    ST_REPLACED   = 4'd1,
    ST_REMOVED    = 4'd2,
    ST_NOT_FOUND  = 4'd3,
    ST_BAD_REMOVE = 4'd4,
    ST_ZERO_PRICE = 4'd5,
    ST_APPENDED   = 4'd6,
    ST_SIDE_FULL  = 4'd7,
    ST_CLEARED    = 4'd8,
    ST_NOT_KEPT   = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    M_NONE   = 2'd0,
    M_INSERT = 2'd1,
    M_REMOVE = 2'd2,
    M_APPEND = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_CMP   = 2'd1,
    FSM_APPLY = 2'd2
  } fsm_t;

  typedef struct packed {
    logic               cmp_en;
    logic               apply_en;
    mode_t              mode;
    logic [PRICE_W-1:0] price;
    logic [SIZE_W-1:0]  size;
    logic [TOL_W-1:0]   tol;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/splb_cell.sv =====
// One price level cell: holds a level, compares it, shifts with its neighbors.
module splb_cell #(
  parameter int LEVELS = splb_pkg::LEVELS_DEF,
  parameter int IDX    = 0,
  parameter bit BID    = 1'b1,
  parameter int FILL_W = $clog2(LEVELS + 1)
) (
  input  logic                         clk,
  input  splb_pkg::cell_ctrl_t         ctrl,
  input  logic [FILL_W-1:0]            fill,
  input  logic                         any_hit,
  input  logic                         rep_any,
  input  logic [splb_pkg::PRICE_W-1:0] lft_price,
  input  logic [splb_pkg::SIZE_W-1:0]  lft_size,
  input  logic                         lft_ge,
  input  logic                         lft_seen,
  input  logic [splb_pkg::PRICE_W-1:0] rgt_price,
  input  logic [splb_pkg::SIZE_W-1:0]  rgt_size,
  output logic [splb_pkg::PRICE_W-1:0] price_r,
  output logic [splb_pkg::SIZE_W-1:0]  size_r,
  output logic                         hit_r,
  output logic                         ge,
  output logic                         seen,
  output logic                         rep_first
);
  import splb_pkg::*;

  localparam logic [FILL_W-1:0] MY_IDX = FILL_W'(IDX);

  logic               vld;
  logic               beats;
  logic               same;
  logic [PRICE_W-1:0] diff;
  logic               rep_r;
  logic               hit_nxt;
  logic               rep_nxt;

  assign vld  = MY_IDX < fill;
  assign diff = (ctrl.price > price_r) ? ctrl.price - price_r : price_r - ctrl.price;
  assign same = (diff == '0) || (diff < PRICE_W'(ctrl.tol));
  assign beats = BID ? (ctrl.price > price_r) : (ctrl.price < price_r);

  always_comb begin
    hit_nxt = 1'b0;
    rep_nxt = 1'b0;
    unique case (ctrl.mode)
      M_INSERT: begin
        hit_nxt = vld & (beats | same);
        rep_nxt = vld & same & ~beats;
      end
      M_REMOVE: hit_nxt = vld & same;
      default:  hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      hit_r <= hit_nxt;
      rep_r <= rep_nxt;
    end
  end

  assign seen      = lft_seen | hit_r;
  assign rep_first = hit_r & ~lft_seen & rep_r;
  assign ge        = seen | (~any_hit & (MY_IDX >= fill));

  always_ff @(posedge clk) begin
    if (ctrl.apply_en) begin
      unique case (ctrl.mode)
        M_INSERT: begin
          if (rep_any) begin
            if (rep_first) size_r <= ctrl.size;
          end else if (lft_ge) begin
            price_r <= lft_price;
            size_r  <= lft_size;
          end else if (ge) begin
            price_r <= ctrl.price;
            size_r  <= ctrl.size;
          end
        end
        M_REMOVE: begin
          if (seen) begin
            price_r <= rgt_price;
            size_r  <= rgt_size;
          end
        end
        M_APPEND: begin
          if (MY_IDX == fill) begin
            price_r <= ctrl.price;
            size_r  <= ctrl.size;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/splb_row.sv =====
// One side of the book: a row of level cells chained best to worst.
module splb_row #(
  parameter int LEVELS = splb_pkg::LEVELS_DEF,
  parameter bit BID    = 1'b1,
  parameter int FILL_W = $clog2(LEVELS + 1)
) (
  input  logic                         clk,
  input  splb_pkg::cell_ctrl_t         ctrl,
  input  logic [FILL_W-1:0]            fill,
  output logic                         any_hit,
  output logic                         rep_any,
  output logic [splb_pkg::PRICE_W-1:0] head_price
);
  import splb_pkg::*;

  logic [PRICE_W-1:0] price_w [LEVELS];
  logic [SIZE_W-1:0]  size_w  [LEVELS];
  logic [LEVELS-1:0]  hit_w;
  logic [LEVELS-1:0]  ge_w;
  logic [LEVELS-1:0]  seen_w;
  logic [LEVELS-1:0]  rep_w;

  assign any_hit    = |hit_w;
  assign rep_any    = |rep_w;
  assign head_price = price_w[0];

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    logic [PRICE_W-1:0] lp;
    logic [SIZE_W-1:0]  ls;
    logic               lg;
    logic               lsn;
    logic [PRICE_W-1:0] rp;
    logic [SIZE_W-1:0]  rs;
    if (i == 0) begin : g_first
      assign lp  = price_w[0];
      assign ls  = size_w[0];
      assign lg  = 1'b0;
      assign lsn = 1'b0;
    end else begin : g_mid
      assign lp  = price_w[i-1];
      assign ls  = size_w[i-1];
      assign lg  = ge_w[i-1];
      assign lsn = seen_w[i-1];
    end
    if (i == LEVELS - 1) begin : g_last
      assign rp = price_w[i];
      assign rs = size_w[i];
    end else begin : g_next
      assign rp = price_w[i+1];
      assign rs = size_w[i+1];
    end
    splb_cell #(.LEVELS(LEVELS), .IDX(i), .BID(BID), .FILL_W(FILL_W)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .fill      (fill),
      .any_hit   (any_hit),
      .rep_any   (rep_any),
      .lft_price (lp),
      .lft_size  (ls),
      .lft_ge    (lg),
      .lft_seen  (lsn),
      .rgt_price (rp),
      .rgt_size  (rs),
      .price_r   (price_w[i]),
      .size_r    (size_w[i]),
      .hit_r     (hit_w[i]),
      .ge        (ge_w[i]),
      .seen      (seen_w[i]),
      .rep_first (rep_w[i])
    );
  end

endmodule

// ===== rtl/core/sorted_price_level_book_top.sv =====
// Top level of the sorted price level book.
//
// Usage:
//   Input requests: drive in_cmd, in_price, in_order_count and in_amount and
//   raise start; the request is taken at a rising edge with start high and
//   busy low. Update (insert, replace or remove a level), clear and snapshot
//   append are supported.
//   Result: out_valid pulses for one cycle with out_status, both fill counts
//   and the best price of each side. The receiver cannot stall; results are
//   never held back.
//   Timing: a request passes the compare stage of each level cell and then
//   the apply stage, where the first-hit chain along the row picks the
//   insert or remove position and all cells shift at once; the result is
//   registered at the end of apply. The next request can be taken at the
//   edge that ends that result cycle, so requests never overlap.
//   Configuration: APB-style port, price_tolerance at address 0. Write only
//   while busy is low and no result is pending.
//   Reset (rst_n low, synchronous): both sides empty, tolerance zero, no
//   result pending. Level storage is not cleared; entries past the fill
//   are never read.
module sorted_price_level_book_top #(
  parameter int LEVELS = splb_pkg::LEVELS_DEF,
  parameter int FILL_W = $clog2(LEVELS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [splb_pkg::CMD_W-1:0]    in_cmd,
  input  logic [splb_pkg::PRICE_W-1:0]  in_price,
  input  logic [splb_pkg::COUNT_W-1:0]  in_order_count,
  input  logic signed [splb_pkg::SIZE_W-1:0] in_amount,
  output logic                          out_valid,
  output logic [splb_pkg::STATUS_W-1:0] out_status,
  output logic [FILL_W-1:0]             out_bid_levels_used,
  output logic [FILL_W-1:0]             out_ask_levels_used,
  output logic [splb_pkg::PRICE_W-1:0]  out_best_bid_price,
  output logic [splb_pkg::PRICE_W-1:0]  out_best_ask_price,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import splb_pkg::*;

  `include "sorted_price_level_book_top_defines.svh"

  localparam logic [FILL_W-1:0] FULL = FILL_W'(LEVELS);

  fsm_t               state_r, state_nxt;
  logic               cmp_en, apply_en;
  logic [TOL_W-1:0]   tol_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [PRICE_W-1:0] price_r;
  logic [COUNT_W-1:0] count_r;
  logic [SIZE_W-1:0]  amt_r;
  logic [FILL_W-1:0]  bid_fill_r, bid_fill_nxt;
  logic [FILL_W-1:0]  ask_fill_r, ask_fill_nxt;
  logic               out_valid_r;
  status_t            status_r, status_nxt;

  logic               neg, is_bid;
  logic [SIZE_W-1:0]  mag;
  mode_t              bid_mode, ask_mode;
  logic [SIZE_W-1:0]  new_size;
  cell_ctrl_t         bid_ctrl, ask_ctrl;
  logic               bid_hit, bid_rep, ask_hit, ask_rep;
  logic [PRICE_W-1:0] bid_head, ask_head;
  logic               accept;

  assign accept = start & ~busy;
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? 32'(tol_r) : 32'd0;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

  // Hold the request for the compare and apply cycles.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      price_r <= in_price;
      count_r <= in_order_count;
      amt_r   <= in_amount;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE:  if (start) state_nxt = FSM_CMP;
      FSM_CMP:   state_nxt = FSM_APPLY;
      FSM_APPLY: state_nxt = FSM_IDLE;
      default:   state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    cmp_en   = 1'b0;
    apply_en = 1'b0;
    unique case (state_r)
      FSM_IDLE:  busy = 1'b0;
      FSM_CMP:   cmp_en = 1'b1;
      FSM_APPLY: apply_en = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode side and operation from the held request.
  assign neg    = amt_r[SIZE_W-1];
  assign is_bid = ~neg & (amt_r != '0);
  assign mag    = neg ? (~amt_r + SIZE_W'(1)) : amt_r;

  always_comb begin
    bid_mode = M_NONE;
    ask_mode = M_NONE;
    new_size = mag;
    unique case (cmd_t'(cmd_r))
      CMD_UPDATE: begin
        if (price_r != '0) begin
          if (count_r == '0) begin
            if (amt_r == ONE_FX) bid_mode = M_REMOVE;
            else if (amt_r == NEG_ONE_FX) ask_mode = M_REMOVE;
          end else if (is_bid) begin
            bid_mode = M_INSERT;
          end else begin
            ask_mode = M_INSERT;
          end
        end
      end
      CMD_APPEND: begin
        if (count_r == '0) new_size = '0;
        if (is_bid) bid_mode = M_APPEND;
        else ask_mode = M_APPEND;
      end
      default: begin
      end
    endcase
  end

  assign bid_ctrl = '{cmp_en: cmp_en, apply_en: apply_en, mode: bid_mode,
                      price: price_r, size: new_size, tol: tol_r};
  assign ask_ctrl = '{cmp_en: cmp_en, apply_en: apply_en, mode: ask_mode,
                      price: price_r, size: new_size, tol: tol_r};

  splb_row #(.LEVELS(LEVELS), .BID(1'b1), .FILL_W(FILL_W)) u_bid (
    .clk        (clk),
    .ctrl       (bid_ctrl),
    .fill       (bid_fill_r),
    .any_hit    (bid_hit),
    .rep_any    (bid_rep),
    .head_price (bid_head)
  );

  splb_row #(.LEVELS(LEVELS), .BID(1'b0), .FILL_W(FILL_W)) u_ask (
    .clk        (clk),
    .ctrl       (ask_ctrl),
    .fill       (ask_fill_r),
    .any_hit    (ask_hit),
    .rep_any    (ask_rep),
    .head_price (ask_head)
  );

  // Resolve status and new fills in the apply cycle.
  always_comb begin
    bid_fill_nxt = bid_fill_r;
    ask_fill_nxt = ask_fill_r;
    status_nxt   = ST_NOT_KEPT;
    unique case (cmd_t'(cmd_r))
      CMD_UPDATE: begin
        if (price_r == '0) begin
          status_nxt = ST_ZERO_PRICE;
        end else if (count_r == '0) begin
          if (amt_r == ONE_FX) begin
            status_nxt = bid_hit ? ST_REMOVED : ST_NOT_FOUND;
            if (bid_hit) bid_fill_nxt = bid_fill_r - FILL_W'(1);
          end else if (amt_r == NEG_ONE_FX) begin
            status_nxt = ask_hit ? ST_REMOVED : ST_NOT_FOUND;
            if (ask_hit) ask_fill_nxt = ask_fill_r - FILL_W'(1);
          end else begin
            status_nxt = ST_BAD_REMOVE;
          end
        end else if (is_bid) begin
          if (bid_rep) status_nxt = ST_REPLACED;
          else if (!bid_hit && bid_fill_r >= FULL) status_nxt = ST_NOT_KEPT;
          else if (bid_fill_r < FULL) begin
            status_nxt   = ST_INSERTED;
            bid_fill_nxt = bid_fill_r + FILL_W'(1);
          end else status_nxt = ST_SIDE_FULL;
        end else begin
          if (ask_rep) status_nxt = ST_REPLACED;
          else if (!ask_hit && ask_fill_r >= FULL) status_nxt = ST_NOT_KEPT;
          else if (ask_fill_r < FULL) begin
            status_nxt   = ST_INSERTED;
            ask_fill_nxt = ask_fill_r + FILL_W'(1);
          end else status_nxt = ST_SIDE_FULL;
        end
      end
      CMD_CLEAR: begin
        bid_fill_nxt = '0;
        ask_fill_nxt = '0;
        status_nxt   = ST_CLEARED;
      end
      CMD_APPEND: begin
        if (is_bid) begin
          if (bid_fill_r < FULL) begin
            status_nxt   = ST_APPENDED;
            bid_fill_nxt = bid_fill_r + FILL_W'(1);
          end
        end else if (ask_fill_r < FULL) begin
          status_nxt   = ST_APPENDED;
          ask_fill_nxt = ask_fill_r + FILL_W'(1);
        end
      end
      default: status_nxt = ST_NOT_KEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bid_fill_r  <= '0;
      ask_fill_r  <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_NOT_KEPT;
    end else begin
      out_valid_r <= apply_en;
      if (apply_en) begin
        bid_fill_r <= bid_fill_nxt;
        ask_fill_r <= ask_fill_nxt;
        status_r   <= status_nxt;
      end
    end
  end

  // Drive the result from state that holds still until the next apply.
  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_bid_levels_used = bid_fill_r;
  assign out_ask_levels_used = ask_fill_r;
  assign out_best_bid_price  = (bid_fill_r != '0) ? bid_head : '0;
  assign out_best_ask_price  = (ask_fill_r != '0) ? ask_head : '0;

  `SPLB_ASSERT_NEXT(a_accept_cmp, accept, state_r == FSM_CMP, "request did not enter compare")
  `SPLB_ASSERT_NOW(a_fill_bound, 1'b1, bid_fill_r <= FULL && ask_fill_r <= FULL, "fill overflow")
  `SPLB_ASSERT_NEXT(a_one_strobe, out_valid_r, !out_valid_r, "result strobe longer than a cycle")
  `SPLB_ASSERT_NOW(a_rep_keeps_fill, out_valid_r && status_r == ST_REPLACED, bid_fill_r == $past(bid_fill_r) && ask_fill_r == $past(ask_fill_r), "replace changed a fill")

endmodule
